[hdl/rmq_pkg.sv]
// Shared types and constants of the matrix-to-quaternion pipeline.
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int MW = CW - 1;
  localparam int SW = 2 * MW + 2;
  localparam int NW = SW / 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int DW = MW + FRAC_BITS + 1;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  typedef struct packed {
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r13;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r23;
    logic signed [15:0] r31;
    logic signed [15:0] r32;
    logic signed [15:0] r33;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [1:0]         branch_taken;
    logic               degenerate;
  } out_req_t;

  typedef struct packed {
    branch_e             br;
    logic                degen;
    logic [3:0]          neg;
    logic [3:0][MW-1:0]  mag;
  } side_t;

endpackage

[hdl/rmq_front.sv]
// Branch select, component forming, squaring and sum of squares (three stages).
module rmq_front import rmq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  in_req_t       req_i,
  output logic          valid_o,
  output logic [SW-1:0] sum_o,
  output side_t         side_o
);

  localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic signed [CW-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33, tr;
  logic signed [CW-1:0] c_d [4];
  branch_e              br_d;

  logic signed [CW-1:0] c_q [4];
  branch_e              br1_q, br2_q;
  logic [3:0][MW-1:0]   mag_q;
  logic [3:0]           neg_q;
  logic [2*MW-1:0]      sq_q [4];
  logic [SW-1:0]        sum_q;
  side_t                side_q;
  logic                 v1_q, v2_q, v3_q;

  assign a11 = {{(CW-16){req_i.r11[15]}}, req_i.r11};
  assign a12 = {{(CW-16){req_i.r12[15]}}, req_i.r12};
  assign a13 = {{(CW-16){req_i.r13[15]}}, req_i.r13};
  assign a21 = {{(CW-16){req_i.r21[15]}}, req_i.r21};
  assign a22 = {{(CW-16){req_i.r22[15]}}, req_i.r22};
  assign a23 = {{(CW-16){req_i.r23[15]}}, req_i.r23};
  assign a31 = {{(CW-16){req_i.r31[15]}}, req_i.r31};
  assign a32 = {{(CW-16){req_i.r32[15]}}, req_i.r32};
  assign a33 = {{(CW-16){req_i.r33[15]}}, req_i.r33};
  assign tr  = a11 + a22 + a33;

  always_comb begin
    if (tr > 0) begin
      br_d   = BR_TRACE;
      c_d[0] = ONE_C + tr;
      c_d[1] = a32 - a23;
      c_d[2] = a13 - a31;
      c_d[3] = a21 - a12;
    end else if (a11 > a22 && a11 > a33) begin
      br_d   = BR_X;
      c_d[0] = a32 - a23;
      c_d[1] = ONE_C + a11 - a22 - a33;
      c_d[2] = a21 + a12;
      c_d[3] = a31 + a13;
    end else if (a22 > a33) begin
      br_d   = BR_Y;
      c_d[0] = a13 - a31;
      c_d[1] = a21 + a12;
      c_d[2] = ONE_C - a11 + a22 - a33;
      c_d[3] = a32 + a23;
    end else begin
      br_d   = BR_Z;
      c_d[0] = a21 - a12;
      c_d[1] = a31 + a13;
      c_d[2] = a32 + a23;
      c_d[3] = ONE_C - a11 - a22 + a33;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        c_q[i]   <= c_d[i];
        neg_q[i] <= c_q[i][CW-1];
        mag_q[i] <= c_q[i][CW-1] ? MW'(-c_q[i]) : MW'(c_q[i]);
        sq_q[i]  <= (c_q[i][CW-1] ? MW'(-c_q[i]) : MW'(c_q[i]))
                  * (c_q[i][CW-1] ? MW'(-c_q[i]) : MW'(c_q[i]));
      end
      br1_q <= br_d;
      br2_q <= br1_q;
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
      side_q.br    <= br2_q;
      side_q.degen <= (sq_q[0] | sq_q[1] | sq_q[2] | sq_q[3]) == '0;
      side_q.neg   <= neg_q;
      side_q.mag   <= mag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign side_o  = side_q;

endmodule

[hdl/rmq_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt import rmq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] sum_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [NW-1:0] root_o,
  output side_t         side_o
);

  localparam int RW = NW + 2;

  typedef struct packed {
    logic [SW-1:0] s;
    logic [RW-1:0] rem;
    logic [NW-1:0] root;
  } sq_t;

  sq_t   st_q   [NW+1];
  side_t side_q [NW+1];
  logic  v_q    [NW+1];

  assign st_q[0]   = '{s: sum_i, rem: '0, root: '0};
  assign side_q[0] = side_i;
  assign v_q[0]    = valid_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [RW+1:0] remx, trial;
    sq_t           nxt;

    assign remx  = {st_q[k].rem, st_q[k].s[SW-1:SW-2]};
    assign trial = {2'b00, st_q[k].root, 2'b01};

    always_comb begin
      nxt.s = {st_q[k].s[SW-3:0], 2'b00};
      if (remx >= trial) begin
        nxt.rem  = RW'(remx - trial);
        nxt.root = {st_q[k].root[NW-2:0], 1'b1};
      end else begin
        nxt.rem  = RW'(remx);
        nxt.root = {st_q[k].root[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1]   <= nxt;
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign valid_o = v_q[NW];
  assign root_o  = st_q[NW].root;
  assign side_o  = side_q[NW];

endmodule

[hdl/rmq_div.sv]
// Four-lane pipelined rounding divider with saturation and output register.
module rmq_div import rmq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] root_i,
  input  side_t         side_i,
  output logic          valid_o,
  output out_req_t      req_o
);

  localparam int OW = ((QW > 16) ? QW : 16) + 2;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [3:0][DW-1:0] num;
    logic [3:0][NW:0]   rem;
    logic [3:0][QW-1:0] quo;
    logic [NW-1:0]      den;
  } dv_t;

  dv_t      st_q   [QW+1];
  side_t    side_q [QW+1];
  logic     v_q    [QW+1];
  dv_t      prep;
  out_req_t out_q;
  logic     vo_q;

  function automatic logic signed [15:0] sat_out(logic [QW-1:0] q, logic neg);
    logic [QW-1:0]        qc;
    logic signed [OW-1:0] v;
    qc = (q > ONE_Q) ? ONE_Q : q;
    v  = neg ? -$signed(OW'(qc)) : $signed(OW'(qc));
    if (v > $signed(OW'(32767))) v = OW'(32767);
    if (v < -$signed(OW'(32768))) v = -$signed(OW'(32768));
    return v[15:0];
  endfunction

  always_comb begin
    prep.den = root_i;
    for (int i = 0; i < 4; i++) begin
      prep.num[i] = DW'({side_i.mag[i], {FRAC_BITS{1'b0}}}) + DW'(root_i >> 1);
      prep.rem[i] = (NW+1)'(prep.num[i][DW-1:QW]);
      prep.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= prep;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    dv_t nxt;

    always_comb begin
      logic [NW:0] remx;
      nxt.den = st_q[k].den;
      for (int i = 0; i < 4; i++) begin
        remx        = {st_q[k].rem[i][NW-1:0], st_q[k].num[i][QW-1-k]};
        nxt.num[i]  = st_q[k].num[i];
        if (remx >= {1'b0, st_q[k].den}) begin
          nxt.rem[i] = remx - {1'b0, st_q[k].den};
          nxt.quo[i] = {st_q[k].quo[i][QW-2:0], 1'b1};
        end else begin
          nxt.rem[i] = remx;
          nxt.quo[i] = {st_q[k].quo[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1]   <= nxt;
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.branch_taken <= side_q[QW].br;
      out_q.degenerate   <= side_q[QW].degen;
      if (side_q[QW].degen) begin
        out_q.qw <= '0;
        out_q.qx <= '0;
        out_q.qy <= '0;
        out_q.qz <= '0;
      end else begin
        out_q.qw <= sat_out(st_q[QW].quo[0], side_q[QW].neg[0]);
        out_q.qx <= sat_out(st_q[QW].quo[1], side_q[QW].neg[1]);
        out_q.qy <= sat_out(st_q[QW].quo[2], side_q[QW].neg[2]);
        out_q.qz <= sat_out(st_q[QW].quo[3], side_q[QW].neg[3]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[QW];
    end
  end

  assign valid_o = vo_q;
  assign req_o   = out_q;

endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+------------------------------
//  input   | in_valid_i | in_ready_o | in_req_i  (nine matrix entries)
//  output  | out_valid_o| out_ready_i| out_req_o (quaternion, branch, flag)
//
// One matrix per cycle while the output is not stalled; the pipeline depth is
// set by the one-bit-per-stage square root and divider.
// Reset clears all stage valid bits; payload registers are not reset.
// A held output request freezes the whole pipeline; nothing is dropped.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  logic          en;
  logic          f_valid, s_valid;
  logic [SW-1:0] f_sum;
  logic [NW-1:0] s_root;
  side_t         f_side, s_side;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (f_valid),
    .sum_o   (f_sum),
    .side_o  (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .sum_i   (f_sum),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (out_valid_o),
    .req_o   (out_req_o)
  );

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.degenerate |->
      out_req_o.qw == '0 && out_req_o.qx == '0 && out_req_o.qy == '0 && out_req_o.qz == '0)
    else $error("degenerate result with nonzero components");

  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.degenerate |->
      out_req_o.qw != '0 || out_req_o.qx != '0 || out_req_o.qy != '0 || out_req_o.qz != '0)
    else $error("normalized result is all zero");

  a_trace_scalar_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.degenerate && out_req_o.branch_taken == BR_TRACE |->
      !out_req_o.qw[15])
    else $error("trace branch gave negative scalar part");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

endmodule
